[rtl/clock_display_scan_multiplexer_defines.svh]
// assertion macros for the clock display scan multiplexer
`ifndef CLOCK_DISPLAY_SCAN_MULTIPLEXER_DEFINES_SVH
`define CLOCK_DISPLAY_SCAN_MULTIPLEXER_DEFINES_SVH

// same-cycle implication, disabled while reset is active
`define CDSM_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is active
`define CDSM_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/cdsm_pkg.sv]
// shared types, codes and the digit glyph table for the display scan multiplexer
`default_nettype none

package cdsm_pkg;

	localparam int unsigned SCAN_W  = 8;
	localparam int unsigned BLINK_W = 16;
	localparam int unsigned CFG_W   = 16;
	localparam int unsigned TIME_W  = 32;
	localparam int unsigned VAL_W   = 6;
	localparam int unsigned SLOT_W  = 3;

	localparam logic [SCAN_W-1:0]  SCAN_PERIOD_RST    = 8'd3;
	localparam logic [BLINK_W-1:0] BLINK_INTERVAL_RST = 16'd500;

	localparam logic [VAL_W-1:0] VALUE_MAX = 6'd59;

	// configuration register indexes
	localparam logic REG_SCAN_PERIOD    = 1'b0;
	localparam logic REG_BLINK_INTERVAL = 1'b1;

	// mode codes
	localparam logic [1:0] MODE_SHOW    = 2'd0;
	localparam logic [1:0] MODE_SET_MIN = 2'd1;
	localparam logic [1:0] MODE_SET_SEC = 2'd2;
	localparam logic [1:0] MODE_ALARM   = 2'd3;

	// display positions
	localparam logic [SLOT_W-1:0] SLOT_MIN_TENS = 3'd0;
	localparam logic [SLOT_W-1:0] SLOT_MIN_UNIT = 3'd1;
	localparam logic [SLOT_W-1:0] SLOT_SEC_TENS = 3'd2;
	localparam logic [SLOT_W-1:0] SLOT_SEC_UNIT = 3'd3;
	localparam logic [SLOT_W-1:0] SLOT_COLON    = 3'd4;

	localparam logic [3:0] EN_ALL_OFF = 4'b1111;
	localparam logic [3:0] EN_COLON   = 4'b1101;

	typedef struct packed {
		logic              scan;
		logic              blink_on;
		logic [SLOT_W-1:0] slot;
	} scan_info_t;

	// segments a..g, a in bit 6
	function automatic logic [6:0] digit_glyph(input logic [3:0] digit);
		logic [6:0] g;
		case (digit)
			4'd0: g = 7'h7E;
			4'd1: g = 7'h30;
			4'd2: g = 7'h6D;
			4'd3: g = 7'h79;
			4'd4: g = 7'h33;
			4'd5: g = 7'h5B;
			4'd6: g = 7'h5F;
			4'd7: g = 7'h70;
			4'd8: g = 7'h7F;
			4'd9: g = 7'h7B;
			default: g = 7'h7E;
		endcase
		return g;
	endfunction

endpackage

`default_nettype wire

[rtl/cdsm_timer.sv]
// scan and blink timing state with the configuration registers
`default_nettype none

module cdsm_timer (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic                          cfg_index,
	input  wire logic [cdsm_pkg::CFG_W-1:0]    cfg_data,
	input  wire logic [cdsm_pkg::TIME_W-1:0]   time_ms,
	input  wire logic                          fire,
	output cdsm_pkg::scan_info_t               info
);
	import cdsm_pkg::*;

	logic [SCAN_W-1:0]  scan_period_q;
	logic [BLINK_W-1:0] blink_interval_q;
	logic [TIME_W-1:0]  last_scan_q;
	logic [TIME_W-1:0]  last_blink_q;
	logic               blink_on_q;
	logic [SLOT_W-1:0]  slot_q;

	logic [TIME_W-1:0]  scan_age;
	logic [TIME_W-1:0]  blink_age;
	logic               blink_due;
	logic [SLOT_W-1:0]  slot_cur;

	always_comb begin
		scan_age  = time_ms - last_scan_q;
		blink_age = time_ms - last_blink_q;
		blink_due = blink_age >= {{(TIME_W-BLINK_W){1'b0}}, blink_interval_q};
		// out-of-range slot codes count as the first position
		slot_cur  = (slot_q > SLOT_COLON) ? SLOT_MIN_TENS : slot_q;
		info.scan     = scan_age >= {{(TIME_W-SCAN_W){1'b0}}, scan_period_q};
		info.blink_on = blink_due ? ~blink_on_q : blink_on_q;
		info.slot     = slot_cur;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_period_q    <= SCAN_PERIOD_RST;
			blink_interval_q <= BLINK_INTERVAL_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SCAN_PERIOD:    scan_period_q    <= cfg_data[SCAN_W-1:0];
				REG_BLINK_INTERVAL: blink_interval_q <= cfg_data[BLINK_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_scan_q  <= '0;
			last_blink_q <= '0;
			blink_on_q   <= 1'b0;
			slot_q       <= SLOT_MIN_TENS;
		end else if (fire && info.scan) begin
			last_scan_q <= time_ms;
			blink_on_q  <= info.blink_on;
			if (blink_due) begin
				last_blink_q <= time_ms;
			end
			slot_q <= (slot_cur == SLOT_COLON) ? SLOT_MIN_TENS : slot_cur + 3'd1;
		end
	end

endmodule

`default_nettype wire

[rtl/cdsm_decode.sv]
// digit split, blanking and seven-segment decode for one display position
`default_nettype none

module cdsm_decode (
	input  wire logic [1:0]                    mode,
	input  wire logic [cdsm_pkg::VAL_W-1:0]    clock_minutes,
	input  wire logic [cdsm_pkg::VAL_W-1:0]    clock_seconds,
	input  wire logic [cdsm_pkg::VAL_W-1:0]    alarm_minutes,
	input  wire logic [cdsm_pkg::VAL_W-1:0]    alarm_seconds,
	input  cdsm_pkg::scan_info_t               info,
	output logic [6:0]                         seg,
	output logic [3:0]                         en,
	output logic                               pt
);
	import cdsm_pkg::*;

	logic [VAL_W-1:0] mins_raw;
	logic [VAL_W-1:0] secs_raw;
	logic [VAL_W-1:0] mins;
	logic [VAL_W-1:0] secs;
	logic [VAL_W-1:0] val;
	logic [10:0]      prod;
	logic [3:0]       tens;
	logic [VAL_W-1:0] units_w;
	logic [3:0]       digit;
	logic             blank;

	always_comb begin
		if (mode inside {MODE_SET_MIN, MODE_SET_SEC}) begin
			mins_raw = alarm_minutes;
			secs_raw = alarm_seconds;
		end else begin
			mins_raw = clock_minutes;
			secs_raw = clock_seconds;
		end
		mins = (mins_raw > VALUE_MAX) ? VALUE_MAX : mins_raw;
		secs = (secs_raw > VALUE_MAX) ? VALUE_MAX : secs_raw;

		val = (info.slot inside {SLOT_MIN_TENS, SLOT_MIN_UNIT}) ? mins : secs;
		// divide by ten via multiply by 13 and shift, exact for 0..59
		prod    = {5'd0, val} * 11'd13;
		tens    = {1'b0, prod[9:7]};
		units_w = val - ({2'b0, tens} * 6'd10);

		case (info.slot)
			SLOT_MIN_TENS, SLOT_SEC_TENS: digit = tens;
			default:                      digit = units_w[3:0];
		endcase

		seg   = '0;
		en    = EN_ALL_OFF;
		pt    = 1'b0;
		blank = 1'b0;
		if (info.slot == SLOT_COLON) begin
			if (!(mode == MODE_ALARM && !info.blink_on)) begin
				en = EN_COLON;
				pt = 1'b1;
			end
		end else begin
			if (info.slot inside {SLOT_MIN_TENS, SLOT_MIN_UNIT}) begin
				blank = (mode == MODE_SET_MIN) && !info.blink_on;
			end else begin
				blank = (mode == MODE_SET_SEC) && !info.blink_on;
			end
			if (!blank) begin
				seg = digit_glyph(digit);
				en  = ~(4'b0001 << info.slot[1:0]);
			end
		end
	end

endmodule

`default_nettype wire

[rtl/clock_display_scan_multiplexer.sv]
// top level of the four-digit clock display scan multiplexer
//
// usage:
// - input channel (in_valid/in_stall) carries one request per millisecond
//   sample: timestamp, mode, clock and alarm minutes and seconds
// - each request first lands in an input register; there it is
//   checked against the scan period and, if due, decoded for the current
//   display position into the output register
// - output channel (out_valid/out_stall) delivers segments, active-low
//   digit enables and the colon point; a request that is not due yields none
// - out_valid rises when a due request moves from the input register into
//   the output register; one request per cycle is sustained unless the
//   output stalls, set by the single timing compare and decode stage
// - a stalled output holds its result; the input register still drains
//   requests that produce no result, and stalls only when a due request
//   finds the output full and stalled
// - configuration writes (cfg_we, cfg_index, cfg_data) take effect at once
//   and belong to idle periods
// - reset clears timing state: scan and blink references to 0, blink off,
//   first position, both channels empty, configuration registers to defaults
`default_nettype none

module clock_display_scan_multiplexer (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic                        cfg_index,
	input  wire logic [cdsm_pkg::CFG_W-1:0]  cfg_data,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic [cdsm_pkg::TIME_W-1:0] time_ms,
	input  wire logic [1:0]                  mode,
	input  wire logic [cdsm_pkg::VAL_W-1:0]  clock_minutes,
	input  wire logic [cdsm_pkg::VAL_W-1:0]  clock_seconds,
	input  wire logic [cdsm_pkg::VAL_W-1:0]  alarm_minutes,
	input  wire logic [cdsm_pkg::VAL_W-1:0]  alarm_seconds,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic [6:0]                       segment_lines,
	output logic [3:0]                       digit_enables,
	output logic                             point_line
);
	import cdsm_pkg::*;

`include "clock_display_scan_multiplexer_defines.svh"

	// input register
	logic              valid_s1;
	logic [TIME_W-1:0] time_s1;
	logic [1:0]        mode_s1;
	logic [VAL_W-1:0]  cmin_s1;
	logic [VAL_W-1:0]  csec_s1;
	logic [VAL_W-1:0]  amin_s1;
	logic [VAL_W-1:0]  asec_s1;

	// output register
	logic              out_valid_q;
	logic [6:0]        seg_q;
	logic [3:0]        en_q;
	logic              pt_q;

	scan_info_t        info;
	logic [6:0]        seg_d;
	logic [3:0]        en_d;
	logic              pt_d;
	logic              advance;
	logic              in_take;

	// a request with no result never waits on the output
	assign advance  = valid_s1 && (!info.scan || !out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			time_s1 <= time_ms;
			mode_s1 <= mode;
			cmin_s1 <= clock_minutes;
			csec_s1 <= clock_seconds;
			amin_s1 <= alarm_minutes;
			asec_s1 <= alarm_seconds;
		end
	end

	cdsm_timer u_timer (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.time_ms   (time_s1),
		.fire      (advance),
		.info      (info)
	);

	cdsm_decode u_decode (
		.mode          (mode_s1),
		.clock_minutes (cmin_s1),
		.clock_seconds (csec_s1),
		.alarm_minutes (amin_s1),
		.alarm_seconds (asec_s1),
		.info          (info),
		.seg           (seg_d),
		.en            (en_d),
		.pt            (pt_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && info.scan) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && info.scan) begin
			seg_q <= seg_d;
			en_q  <= en_d;
			pt_q  <= pt_d;
		end
	end

	assign out_valid     = out_valid_q;
	assign segment_lines = seg_q;
	assign digit_enables = en_q;
	assign point_line    = pt_q;

	// a lit digit has exactly one enable low
	`CDSM_ASSERT_IMP(a_one_digit, clk, arst_n, out_valid && segment_lines != 7'd0, $countones(digit_enables) == 3, "lit digit without a single enable")
	// the colon shows alone on digit two
	`CDSM_ASSERT_IMP(a_colon_alone, clk, arst_n, out_valid && point_line, digit_enables == EN_COLON && segment_lines == 7'd0, "colon drive mixed with a digit")
	// input stalls only behind a held request
	`CDSM_ASSERT_IMP(a_stall_cause, clk, arst_n, in_stall, valid_s1 && out_valid_q && out_stall, "input stalled without a blocked request")
	// an accepted request occupies the input register next cycle
	`CDSM_ASSERT_NXT(a_take_fills, clk, arst_n, in_take, valid_s1, "accepted request lost")

endmodule

`default_nettype wire
